// ----- design/itl_pkg.sv -----
// shared types and constants for the interpolation table lookup block
// no dependencies

package itl_pkg;

  localparam int MAX_ROWS    = 1024;
  localparam int NUM_COLUMNS = 4;
  localparam int ADDR_W      = $clog2(MAX_ROWS);
  localparam int COUNT_W     = $clog2(MAX_ROWS + 1);
  localparam int COL_W       = $clog2(NUM_COLUMNS);
  localparam int VAL_W       = 32;
  localparam int ROW_W       = VAL_W * (1 + NUM_COLUMNS);

  // position codes on the result
  localparam logic [1:0] POS_INTERIOR = 2'd0;
  localparam logic [1:0] POS_LOW      = 2'd1;
  localparam logic [1:0] POS_HIGH     = 2'd2;
  localparam logic [1:0] POS_INVALID  = 2'd3;

  // request codes on req_type
  localparam logic REQ_WRITE = 1'b0;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_QUERY   = 2'd1,
    KIND_INVALID = 2'd2
  } kind_t;

  // one queued item, already classified by the front end
  typedef struct packed {
    kind_t                 kind;
    logic [ADDR_W-1:0]     row_index;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      column;
    logic signed [VAL_W-1:0] query_x;
    logic [COUNT_W-1:0]    rows;
  } entry_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic   avail;
    entry_t entry;
  } head_t;

endpackage

// ----- design/itl_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies

module itl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/itl_front.sv -----
// front end: accepts items, classifies them and holds them in a two entry queue
// depends on itl_pkg

module itl_front import itl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     req_type,
  input  logic [ADDR_W-1:0]        row_index,
  input  logic [ROW_W-1:0]         row,
  input  logic [2:0]               column,
  input  logic signed [VAL_W-1:0]  query_x,
  input  logic [COUNT_W-1:0]       rows_in_use,
  input  logic                     pop,
  output head_t                    head
);

  localparam int QDEPTH = 2;

  entry_t           q [QDEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  entry_t           incoming;
  logic [COUNT_W-1:0] rows_eff;

  assign busy = (count == 2'(QDEPTH));
  assign push = start && !busy;

  // clamp the row count to the table size
  assign rows_eff = (rows_in_use > COUNT_W'(MAX_ROWS)) ? COUNT_W'(MAX_ROWS) : rows_in_use;

  // classify the incoming item
  always_comb begin
    incoming.row_index = row_index;
    incoming.row       = row;
    incoming.column    = column[COL_W-1:0];
    incoming.query_x   = query_x;
    incoming.rows      = rows_eff;
    priority if (req_type == REQ_WRITE) begin
      incoming.kind = KIND_WRITE;
    end else if (column >= 3'(NUM_COLUMNS) || rows_eff == '0) begin
      incoming.kind = KIND_INVALID;
    end else begin
      incoming.kind = KIND_QUERY;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= incoming;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign head.avail = (count != '0);
  assign head.entry = q[rd_ptr];

endmodule

// ----- design/itl_back.sv -----
// back end: writes rows, runs the binary search and the interpolation arithmetic
// depends on itl_pkg and itl_ram

module itl_back import itl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  head_t                   head,
  output logic                    pop,
  output logic                    done,
  output logic signed [VAL_W-1:0] interp_value,
  output logic [1:0]              position
);

  localparam int DIFF_W = VAL_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int BLO_W  = 17;
  localparam int REM_W  = DIFF_W + 1;
  localparam int CNT_W  = $clog2(PROD_W);
  localparam int SUM_W  = VAL_W + 3;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_CHK0 = 12'b000000000010,
    S_CHKN = 12'b000000000100,
    S_SRCH = 12'b000000001000,
    S_SCMP = 12'b000000010000,
    S_LO   = 12'b000000100000,
    S_HI   = 12'b000001000000,
    S_MUL1 = 12'b000010000000,
    S_MUL2 = 12'b000100000000,
    S_DIV  = 12'b001000000000,
    S_SUM  = 12'b010000000000,
    S_WAIT = 12'b100000000000
  } state_t;

  state_t                 state;
  entry_t                 cur;
  logic [ADDR_W-1:0]      lo;
  logic [ADDR_W-1:0]      hi;
  logic [ADDR_W-1:0]      mid;
  logic [ADDR_W-1:0]      raddr;
  logic [ROW_W-1:0]       rdata;
  logic                   ram_we;
  logic signed [VAL_W-1:0] rd_x;
  logic signed [VAL_W-1:0] rd_y;
  logic signed [VAL_W-1:0] x0;
  logic signed [VAL_W-1:0] y0;
  logic [DIFF_W-1:0]      mag_a;
  logic [DIFF_W-1:0]      mag_b;
  logic [DIFF_W-1:0]      mag_d;
  logic                   neg;
  logic [PROD_W-1:0]      acc;
  logic [REM_W-1:0]       rem;
  logic [CNT_W-1:0]       cnt;
  logic [ADDR_W-1:0]      last;
  logic [ADDR_W-1:0]      mid_calc;
  logic                   more;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dd;
  logic [REM_W-1:0]       rem_sh;
  logic                   rem_ge;
  logic                   q_sat;
  logic signed [SUM_W-1:0] sum;
  logic [DIFF_W+BLO_W-1:0]   pp_lo;
  logic [2*DIFF_W-BLO_W-1:0] pp_hi;

  assign last     = ADDR_W'(cur.rows - COUNT_W'(1));
  assign mid_calc = lo + ((hi - lo) >> 1);
  assign more     = ({1'b0, lo} + (ADDR_W+1)'(1)) < {1'b0, hi};
  assign rd_x     = rdata[VAL_W-1:0];
  assign rd_y     = rdata[VAL_W*(32'(cur.column)+1) +: VAL_W];

  // take the next queued item when idle
  assign pop    = (state == S_IDLE) && head.avail;
  assign ram_we = pop && head.entry.kind == KIND_WRITE;

  // read address for the next cycle
  always_comb begin
    unique case (state)
      S_CHK0:  raddr = last;
      S_SRCH:  raddr = more ? mid_calc : lo;
      S_LO:    raddr = lo + ADDR_W'(1);
      default: raddr = '0;
    endcase
  end

  itl_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ROWS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head.entry.row_index),
    .wdata (head.entry.row),
    .raddr (raddr),
    .rdata (rdata)
  );

  // bracket differences from the lower row and the upper row on the read port
  assign dy = DIFF_W'(rd_y) - DIFF_W'(y0);
  assign dx = DIFF_W'(cur.query_x) - DIFF_W'(x0);
  assign dd = DIFF_W'(rd_x) - DIFF_W'(x0);

  // partial products of the magnitudes, low and high slice of mag_b
  assign pp_lo = mag_a * mag_b[BLO_W-1:0];
  assign pp_hi = mag_a * mag_b[DIFF_W-1:BLO_W];

  // one restoring division step
  assign rem_sh = {rem[REM_W-2:0], acc[PROD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, mag_d};

  // quotient above 2^33 saturates outright
  assign q_sat = (acc[PROD_W-1:DIFF_W+1] != '0) || (acc[DIFF_W] && acc[DIFF_W-1:0] != '0);
  assign sum   = neg ? SUM_W'(y0) - SUM_W'({1'b0, acc[DIFF_W:0]})
                     : SUM_W'(y0) + SUM_W'({1'b0, acc[DIFF_W:0]});

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (head.avail) begin
            cur <= head.entry;
            unique case (head.entry.kind)
              KIND_WRITE: state <= S_IDLE;
              KIND_QUERY: state <= S_CHK0;
              default: begin
                done         <= 1'b1;
                interp_value <= '0;
                position     <= POS_INVALID;
              end
            endcase
          end
        end
        S_CHK0: begin
          if (cur.query_x <= rd_x) begin
            done         <= 1'b1;
            interp_value <= rd_y;
            position     <= POS_LOW;
            state        <= S_IDLE;
          end else begin
            state <= S_CHKN;
          end
        end
        S_CHKN: begin
          if (cur.query_x >= rd_x) begin
            done         <= 1'b1;
            interp_value <= rd_y;
            position     <= POS_HIGH;
            state        <= S_IDLE;
          end else begin
            lo    <= '0;
            hi    <= last;
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          mid   <= mid_calc;
          state <= more ? S_SCMP : S_LO;
        end
        S_SCMP: begin
          if (rd_x <= cur.query_x) lo <= mid;
          else hi <= mid;
          state <= S_SRCH;
        end
        S_LO: begin
          x0    <= rd_x;
          y0    <= rd_y;
          state <= S_HI;
        end
        S_HI: begin
          mag_a <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
          mag_b <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
          mag_d <= dd[DIFF_W-1] ? DIFF_W'(-dd) : DIFF_W'(dd);
          neg   <= dy[DIFF_W-1] ^ dx[DIFF_W-1] ^ dd[DIFF_W-1];
          if (dd == '0) begin
            done         <= 1'b1;
            interp_value <= y0;
            position     <= POS_INTERIOR;
            state        <= S_IDLE;
          end else begin
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          // low partial product
          acc   <= PROD_W'(pp_lo);
          state <= S_MUL2;
        end
        S_MUL2: begin
          // high partial product
          acc   <= acc + (PROD_W'(pp_hi) << BLO_W);
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          acc <= {acc[PROD_W-2:0], rem_ge};
          rem <= rem_ge ? rem_sh - {1'b0, mag_d} : rem_sh;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(PROD_W - 1)) state <= S_SUM;
        end
        S_SUM: begin
          done     <= 1'b1;
          position <= POS_INTERIOR;
          priority if (q_sat) begin
            interp_value <= neg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
          end else if (sum > SUM_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}))) begin
            interp_value <= {1'b0, {(VAL_W-1){1'b1}}};
          end else if (sum < SUM_W'(signed'({1'b1, {(VAL_W-1){1'b0}}}))) begin
            interp_value <= {1'b1, {(VAL_W-1){1'b0}}};
          end else begin
            interp_value <= VAL_W'(sum);
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result is only raised on the way back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("result strobe outside idle");

  // the search window never collapses
  a_window: assert property (@(posedge clk) disable iff (rst)
    state == S_SRCH |-> lo < hi) else $error("search window empty");

  // the partial remainder stays below the divisor
  a_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < {1'b0, mag_d}) else $error("remainder out of range");

  // an invalid query always answers zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && position == POS_INVALID |-> interp_value == '0)
    else $error("invalid query with nonzero value");

endmodule

// ----- design/interp_table_lookup.sv -----
// top level of the piecewise linear interpolation table
// depends on itl_pkg, itl_front, itl_back (and itl_ram through itl_back)

// Items enter on start while busy is low; a two entry queue lets up to two items
// wait while the back end works. A row write goes to the row memory as it is
// taken from the queue. A query with an invalid column or an empty table is
// answered from idle with position invalid; a clamped query is answered in S_CHK0
// at or below the first row and in S_CHKN at or above the last row. An interior
// query passes the end row checks, a binary search over the single read port of
// the row memory, the bracket reads, a two step multiply, a 66 step restoring
// divider and the final sum. Each result is shown for exactly one cycle with done
// high; the receiver must take it then.
// The user must write rows_in_use through cfg_valid only while the block is idle;
// the block itself does not enforce this. cfg_ready is always high.

module interp_table_lookup import itl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    req_type,
  input  logic [ADDR_W-1:0]       row_index,
  input  logic signed [VAL_W-1:0] row_x,
  input  logic signed [VAL_W-1:0] row_y0,
  input  logic signed [VAL_W-1:0] row_y1,
  input  logic signed [VAL_W-1:0] row_y2,
  input  logic signed [VAL_W-1:0] row_y3,
  input  logic [2:0]              column,
  input  logic signed [VAL_W-1:0] query_x,
  output logic                    done,
  output logic signed [VAL_W-1:0] interp_value,
  output logic [1:0]              position,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [COUNT_W-1:0]      cfg_data
);

  logic [COUNT_W-1:0] rows_in_use;
  head_t              head;
  logic               pop;

  assign cfg_ready = 1'b1;

  // row count register
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      rows_in_use <= cfg_data;
    end
  end

  itl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .row_index   (row_index),
    .row         ({row_y3, row_y2, row_y1, row_y0, row_x}),
    .column      (column),
    .query_x     (query_x),
    .rows_in_use (rows_in_use),
    .pop         (pop),
    .head        (head)
  );

  itl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .done         (done),
    .interp_value (interp_value),
    .position     (position)
  );

endmodule

// ----- tb/sv/interp_table_lookup_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for interp_table_lookup: directed table, then random phases
// checks every result against a local interpolation predictor or a fixed expected answer; depends on itl_pkg

module interp_table_lookup_tb;
  import itl_pkg::*;

  localparam logic REQ_QUERY  = 1'b1;
  localparam int   SETTLE     = 200;
  localparam int   LIMIT      = 1000000;
  localparam int   RAND_ITEMS = 400;

  typedef enum logic [1:0] {OP_CFG, OP_WRITE, OP_QUERY} dir_op_t;

  typedef struct {
    dir_op_t          op;
    logic [10:0]      count;
    logic [9:0]       ridx;
    logic [31:0]      rx;
    logic [31:0]      ry [4];
    logic [2:0]       col;
    logic [31:0]      qx;
    bit               typed;
    logic [31:0]      tv;
    logic [1:0]       tp;
  } dir_row_t;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  pos;
  } answer_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    req_type = 1'b0;
  logic [ADDR_W-1:0]       row_index = '0;
  logic signed [VAL_W-1:0] row_x = '0;
  logic signed [VAL_W-1:0] row_y0 = '0;
  logic signed [VAL_W-1:0] row_y1 = '0;
  logic signed [VAL_W-1:0] row_y2 = '0;
  logic signed [VAL_W-1:0] row_y3 = '0;
  logic [2:0]              column = '0;
  logic signed [VAL_W-1:0] query_x = '0;
  logic                    done;
  logic signed [VAL_W-1:0] interp_value;
  logic [1:0]              position;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [COUNT_W-1:0]      cfg_data = '0;

  // local copy of the table and the row count
  logic signed [31:0] tab_x [MAX_ROWS];
  logic signed [31:0] tab_y [MAX_ROWS][4];
  bit                 written [MAX_ROWS];
  logic [10:0]        rows_cfg;

  answer_t  answers [$];
  dir_row_t dir_rows [$];
  int       errors = 0;
  int       cycles = 0;

  always #10 clk = ~clk;

  interp_table_lookup i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .row_index(row_index), .row_x(row_x), .row_y0(row_y0), .row_y1(row_y1),
    .row_y2(row_y2), .row_y3(row_y3), .column(column), .query_x(query_x),
    .done(done), .interp_value(interp_value), .position(position),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // y0 + (y1-y0)*(x-x0)/(x1-x0), truncated toward zero, saturated
  function automatic logic [31:0] blend(longint x0, longint y0, longint x1, longint y1,
                                        longint x);
    longint       da, db, dd, sum;
    logic [127:0] ma, mb, md, quot;
    bit           neg;
    da = y1 - y0;
    db = x - x0;
    dd = x1 - x0;
    if (dd == 0) return y0[31:0];
    ma = (da < 0) ? -da : da;
    mb = (db < 0) ? -db : db;
    md = (dd < 0) ? -dd : dd;
    neg = ((da < 0) != (db < 0)) != (dd < 0);
    quot = (ma * mb) / md;
    if (quot > 128'h2_0000_0000) return neg ? 32'h8000_0000 : 32'h7fff_ffff;
    sum = neg ? y0 - longint'(quot[63:0]) : y0 + longint'(quot[63:0]);
    if (sum > 64'sh7fff_ffff) sum = 64'sh7fff_ffff;
    if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
    return sum[31:0];
  endfunction

  // expected answer of one query against the local table
  function automatic answer_t lookup_answer(logic [2:0] col, logic signed [31:0] qx);
    answer_t ans;
    int      n, lo, hi, mid;
    n = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
    if (col >= NUM_COLUMNS || n == 0) begin
      ans.value = '0;
      ans.pos   = POS_INVALID;
    end else if (qx <= tab_x[0]) begin
      ans.value = tab_y[0][col];
      ans.pos   = POS_LOW;
    end else if (qx >= tab_x[n-1]) begin
      ans.value = tab_y[n-1][col];
      ans.pos   = POS_HIGH;
    end else begin
      lo = 0;
      hi = n - 1;
      while (lo + 1 < hi) begin
        mid = lo + (hi - lo) / 2;
        if (tab_x[mid] <= qx) lo = mid;
        else hi = mid;
      end
      ans.value = blend(tab_x[lo], tab_y[lo][col], tab_x[lo+1], tab_y[lo+1][col], qx);
      ans.pos   = POS_INTERIOR;
    end
    return ans;
  endfunction

  // one item transfer; start is left high for the caller
  task automatic send_item(logic rt, logic [9:0] ri, logic [31:0] rx, logic [31:0] ry [4],
                           logic [2:0] col, logic [31:0] qx,
                           bit typed, logic [31:0] tv, logic [1:0] tp);
    answer_t ans;
    start     <= 1'b1;
    req_type  <= rt;
    row_index <= ri;
    row_x     <= rx;
    row_y0    <= ry[0];
    row_y1    <= ry[1];
    row_y2    <= ry[2];
    row_y3    <= ry[3];
    column    <= col;
    query_x   <= qx;
    do @(posedge clk); while (busy);
    if (rt == REQ_WRITE) begin
      tab_x[ri] = rx;
      for (int j = 0; j < 4; j++) tab_y[ri][j] = ry[j];
      written[ri] = 1'b1;
    end else if (typed) begin
      ans.value = tv;
      ans.pos   = tp;
      answers = {answers, ans};
    end else begin
      answers = {answers, lookup_answer(col, qx)};
    end
  endtask

  task automatic hold_off(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // wait for the block to drain, then write the row count
  task automatic set_rows(logic [10:0] count);
    start <= 1'b0;
    while (answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rows_cfg = count;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // write every unwritten row that the search for qx will read, ahead of the query
  task automatic cover_path(logic [2:0] col, logic signed [31:0] qx, output int added);
    int          n, lo, hi, mid;
    logic [31:0] py [4];
    longint      px;
    added = 0;
    n = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
    if (col < NUM_COLUMNS && n >= 2 && qx > tab_x[0] && qx < tab_x[n-1]) begin
      lo = 0;
      hi = n - 1;
      while (lo + 1 < hi) begin
        mid = lo + (hi - lo) / 2;
        if (!written[mid]) begin
          for (int j = 0; j < 4; j++) py[j] = rand_value();
          px = longint'(tab_x[lo]) +
               (longint'(tab_x[hi]) - longint'(tab_x[lo])) * (mid - lo) / (hi - lo);
          send_item(REQ_WRITE, 10'(mid), px[31:0], py, 0, 0, 0, 0, 0);
          added++;
        end
        if (tab_x[mid] <= qx) lo = mid;
        else hi = mid;
      end
    end
  endtask

  task automatic add_dir(dir_op_t op, logic [10:0] count, logic [9:0] ridx, logic [31:0] rx,
                         logic [31:0] y0, logic [31:0] y1, logic [31:0] y2, logic [31:0] y3,
                         logic [2:0] col, logic [31:0] qx,
                         bit typed, logic [31:0] tv, logic [1:0] tp);
    dir_row_t r;
    r.op = op; r.count = count; r.ridx = ridx; r.rx = rx;
    r.ry[0] = y0; r.ry[1] = y1; r.ry[2] = y2; r.ry[3] = y3;
    r.col = col; r.qx = qx; r.typed = typed; r.tv = tv; r.tp = tp;
    dir_rows = {dir_rows, r};
  endtask

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (answers.size() == 0) begin
        $display("%0t: unexpected result value %h position %0d", $time, interp_value,
                 position);
        errors++;
      end else begin
        answer_t want;
        want = answers.pop_front();
        if (interp_value !== want.value) begin
          $display("%0t: interp_value expected %h actual %h", $time, want.value,
                   interp_value);
          errors++;
        end
        if (position !== want.pos) begin
          $display("%0t: position expected %0d actual %0d", $time, want.pos, position);
          errors++;
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [31:0] ry [4];
    logic [31:0] qx;
    logic [2:0]  col;
    longint      base, step, step_max, lo_x, hi_x;
    int          m, rand_sent, phase, n_items, r, added;
    bit          idle_on;

    for (int i = 0; i < MAX_ROWS; i++) begin
      written[i] = 1'b0;
      tab_x[i] = '0;
      for (int j = 0; j < 4; j++) tab_y[i][j] = '0;
    end
    rows_cfg = '0;

    // directed part: empty table, extremes, clamps, invalid columns
    add_dir(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 3'd0, 32'h0, 1, 32'h0, POS_INVALID);
    add_dir(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 3'd7, 32'h7fff_ffff, 1, 32'h0, POS_INVALID);
    add_dir(OP_WRITE, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
            32'h0001_2345, 0, 0, 0, 0, 0);
    add_dir(OP_WRITE, 0, 1, 32'hffff_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
            32'hffff_ffff, 0, 0, 0, 0, 0);
    add_dir(OP_WRITE, 0, 2, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0002_0000,
            32'h0, 0, 0, 0, 0, 0);
    add_dir(OP_WRITE, 0, 3, 32'h7fff_ffff, 32'h0, 32'h0, 32'hffff_0000, 32'h7fff_ffff,
            0, 0, 0, 0, 0);
    add_dir(OP_WRITE, 0, 10'h3ff, 32'h5555_aaaa, 32'haaaa_5555, 32'h1, 32'h2, 32'h3,
            0, 0, 0, 0, 0);
    add_dir(OP_CFG, 11'd4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_dir(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 3'd0, 32'h8000_0000, 1, 32'h8000_0000, POS_LOW);
    add_dir(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 3'd1, 32'h7fff_ffff, 1, 32'h0, POS_HIGH);
    add_dir(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 3'd4, 32'h0, 1, 32'h0, POS_INVALID);
    add_dir(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 3'd7, 32'h0, 1, 32'h0, POS_INVALID);
    add_dir(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 3'd0, 32'h0, 0, 0, 0);
    add_dir(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 3'd1, 32'h0000_8000, 0, 0, 0);
    add_dir(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 3'd2, 32'h8000_0001, 0, 0, 0);
    add_dir(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 3'd3, 32'h7fff_fffe, 0, 0, 0);
    add_dir(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 3'd0, 32'hffff_0000, 0, 0, 0);
    // falling breakpoint in the middle
    add_dir(OP_WRITE, 0, 2, 32'hfff0_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h0,
            0, 0, 0, 0, 0);
    add_dir(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 3'd0, 32'h0000_0001, 0, 0, 0);
    add_dir(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 3'd1, 32'hfff8_0000, 0, 0, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      case (dir_rows[k].op)
        OP_CFG: set_rows(dir_rows[k].count);
        OP_WRITE: send_item(REQ_WRITE, dir_rows[k].ridx, dir_rows[k].rx, dir_rows[k].ry,
                            0, 0, 0, 0, 0);
        default: send_item(REQ_QUERY, 0, 0, dir_rows[k].ry, dir_rows[k].col,
                           dir_rows[k].qx, dir_rows[k].typed, dir_rows[k].tv,
                           dir_rows[k].tp);
      endcase
      if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 16));
    end

    // random phases, each with its own row count and table
    rand_sent = 0;
    phase = 0;
    while (rand_sent < RAND_ITEMS) begin
      idle_on = ($urandom_range(0, 2) != 0);
      if (phase == 0) set_rows(11'd2047);
      else if (phase == 1) set_rows(11'd1024);
      else begin
        case ($urandom_range(0, 9))
          0:       set_rows(11'd0);
          1:       set_rows(11'd1);
          2:       set_rows(11'd1024);
          default: set_rows(11'($urandom_range(2, 12)));
        endcase
      end
      m = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;

      // fill the rows in use: mostly rising x, sometimes repeated or arbitrary;
      // a large table gets its end rows here and its search rows per query
      step_max = 64'h1_0000_0000 / (m + 1);
      base = -64'sh8000_0000 + longint'($urandom_range(0, 32'(step_max)));
      r = $urandom_range(0, 4);
      for (int i = 0; i < m; i++) begin
        if (m <= 16 || ((i == 0 || i == m - 1) && !written[i])) begin
          for (int j = 0; j < 4; j++) ry[j] = rand_value();
          send_item(REQ_WRITE, 10'(i), (r == 0) ? $urandom : base[31:0], ry, 0, 0, 0, 0, 0);
          rand_sent++;
          if (idle_on && rand_sent < RAND_ITEMS - 60 && $urandom_range(0, 9) == 0)
            hold_off($urandom_range(1, 16));
        end
        step = (r == 1 && $urandom_range(0, 2) == 0) ? 0 :
               longint'($urandom_range(1, 32'(step_max)));
        if (base + step <= 64'sh7fff_ffff) base = base + step;
      end

      n_items = (m > 16) ? 15 : $urandom_range(20, 40);
      for (int k = 0; k < n_items; k++) begin
        if (phase == 3 && k == n_items / 2) begin
          start <= 1'b0;
          do @(posedge clk); while (answers.size() != 0);
        end
        if ($urandom_range(0, 9) == 0) begin
          // stray row write, anywhere in the store
          for (int j = 0; j < 4; j++) ry[j] = rand_value();
          send_item(REQ_WRITE, 10'($urandom_range(0, MAX_ROWS - 1)), $urandom, ry,
                    0, 0, 0, 0, 0);
        end else begin
          col = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(4, 7)) :
                3'($urandom_range(0, 3));
          case ($urandom_range(0, 9))
            0, 1, 2: qx = $urandom;
            3:       qx = rand_value();
            4:       qx = (m > 0) ? tab_x[$urandom_range(0, m - 1)] : $urandom;
            default: begin
              if (m >= 2) begin
                r = $urandom_range(0, m - 2);
                lo_x = tab_x[r];
                hi_x = tab_x[r+1];
                if (hi_x > lo_x) qx = 32'(lo_x + longint'({$urandom, $urandom} % 
                                                         64'(hi_x - lo_x)));
                else qx = 32'(lo_x);
              end else qx = $urandom;
            end
          endcase
          cover_path(col, qx, added);
          rand_sent += added;
          send_item(REQ_QUERY, 10'($urandom), $urandom, ry, col, qx, 0, 0, 0);
        end
        rand_sent++;
        if (idle_on && rand_sent < RAND_ITEMS - 60 && $urandom_range(0, 7) == 0)
          hold_off($urandom_range(1, 16));
      end
      phase++;
    end

    // drain and let the last row writes settle
    start <= 1'b0;
    while (answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
